@@ design/fpba_pkg.sv @@
// Shared types and constants for the fit-policy block allocator.
`default_nettype none

package fpba_pkg;

  // Table geometry
  localparam int BLOCKS    = 32;
  localparam int SIZE_BITS = 16;
  localparam int IDX_W     = $clog2(BLOCKS);
  localparam int POS_W     = $clog2(BLOCKS + 1);

  // Fixed field widths
  localparam int REQ_W   = 16;
  localparam int COUNT_W = 6;
  localparam int SUM_W   = 21;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_e;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_ALLOC = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_ALLOC  = 2'd1,
    ST_NONE   = 2'd2
  } status_e;

  typedef enum logic {
    CFG_FIT_MODE    = 1'b0,
    CFG_BLOCK_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  // Search token handed from cell to cell
  typedef struct packed {
    logic                 valid;
    kind_e                kind;
    logic [1:0]           mode;
    logic [POS_W-1:0]     lim;
    logic [IDX_W-1:0]     target;
    logic [SIZE_BITS-1:0] req;
    logic                 found;
    logic [IDX_W-1:0]     pick;
    logic [SIZE_BITS-1:0] pick_size;
    logic                 pick_used;
  } pkt_t;

  // Write-back broadcast to the row
  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] size;
    logic                 used;
  } wr_t;

endpackage

`default_nettype wire

@@ design/fpba_cell.sv @@
// One table entry with its stage of the search token chain.
`default_nettype none

module fpba_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [fpba_pkg::IDX_W-1:0]   cell_idx_i,
  input  fpba_pkg::pkt_t               pkt_i,
  input  fpba_pkg::wr_t                wr_i,
  output fpba_pkg::pkt_t               pkt_o
);
  import fpba_pkg::*;

  logic [SIZE_BITS-1:0] size_q;
  logic                 used_q;
  pkt_t                 pkt_d, pkt_q;
  logic                 take;
  logic                 fits;
  logic                 elig;

  // Decide whether this entry replaces the current pick
  always_comb begin
    pkt_d = pkt_i;
    take  = 1'b0;
    fits  = (size_q >= pkt_i.req);
    elig  = (POS_W'(cell_idx_i) < pkt_i.lim);
    if (pkt_i.valid) begin
      if (pkt_i.kind == KIND_ALLOC) begin
        case (pkt_i.mode)
          FIT_BEST:  take = elig && fits && (!pkt_i.found || size_q < pkt_i.pick_size);
          FIT_WORST: take = elig && fits && (!pkt_i.found || size_q > pkt_i.pick_size);
          default:   take = elig && fits && !pkt_i.found;
        endcase
      end else begin
        take = (cell_idx_i == pkt_i.target);
      end
    end
    if (take) begin
      pkt_d.found     = 1'b1;
      pkt_d.pick      = cell_idx_i;
      pkt_d.pick_size = size_q;
      pkt_d.pick_used = used_q;
    end
  end

  // Advance the token one cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q <= '0;
    end else begin
      pkt_q <= pkt_d;
    end
  end

  // Hold the entry, update on a matching write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
      used_q <= 1'b0;
    end else if (wr_i.en && wr_i.idx == cell_idx_i) begin
      size_q <= wr_i.size;
      used_q <= wr_i.used;
    end
  end

  assign pkt_o = pkt_q;

endmodule

`default_nettype wire

@@ design/fit_policy_block_allocator_unit.sv @@
// Top level of the fit-policy block allocator: sequencer, sums and cell row.
//
// Usage: items arrive on the in channel (valid/ready) with kind, block_index
// and size_value; one result per item leaves on the out channel with status,
// chosen_block and both fragmentation sums after the item.
// Each item launches a search token into a row of 32 cells, one cell per
// table entry; the token moves one cell per cycle. An item passes through
// the launch register, the cells and the capture register; the commit
// from the capture register writes the chosen entry back and updates the
// sums. The next item is taken in the cycle the result is registered, so
// no new item enters while one is still in the row. Loads take the same
// path. A waiting result sits in the output register; if the receiver
// stalls past the next item's finish, that item holds in the capture
// register until the output register frees. fit_mode and block_count are
// written through the config port; the user must write them only while
// idle, as the block itself does not enforce it. Reset clears every entry,
// the used marks, both sums and the handshake state; fit_mode resets to
// first fit and block_count to 32.
`default_nettype none

module fit_policy_block_allocator_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_idx_i,
  input  logic [fpba_pkg::COUNT_W-1:0]      cfg_data_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic [fpba_pkg::IDX_W-1:0]        block_index_i,
  input  logic [fpba_pkg::REQ_W-1:0]        size_value_i,
  // results
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [fpba_pkg::IDX_W-1:0]        chosen_block_o,
  output logic [fpba_pkg::SUM_W-1:0]        internal_frag_o,
  output logic [fpba_pkg::SUM_W-1:0]        external_frag_o
);
  import fpba_pkg::*;

  logic [1:0]           fit_mode_q;
  logic [COUNT_W-1:0]   block_count_q;
  state_e               state_q, state_d;
  pkt_t                 launch_q, launch_d;
  pkt_t                 fin_q;
  pkt_t                 pkt [BLOCKS+1];
  logic [BLOCKS:0]      live;
  wr_t                  wr;
  logic                 accept;
  logic                 commit;
  logic [SUM_W-1:0]     int_q, int_d;
  logic [SUM_W-1:0]     ext_q, ext_d;
  logic                 out_valid_q;
  logic [1:0]           status_q, status_d;
  logic [IDX_W-1:0]     chosen_q, chosen_d;
  logic [POS_W-1:0]     lim;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= FIT_FIRST;
      block_count_q <= COUNT_W'(BLOCKS);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FIT_MODE:    fit_mode_q    <= cfg_data_i[1:0];
        CFG_BLOCK_COUNT: block_count_q <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_SCAN;
      S_SCAN:   if (pkt[BLOCKS].valid) state_d = S_FINISH;
      S_FINISH: if (commit) state_d = accept ? S_SCAN : S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    commit     = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);
    in_ready_o = (state_q == S_IDLE) || commit;
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Clamp the search length to the table
  assign lim = (block_count_q > COUNT_W'(BLOCKS)) ? POS_W'(BLOCKS) : POS_W'(block_count_q);

  // Build the token for an accepted item
  always_comb begin
    launch_d           = '0;
    launch_d.valid     = accept;
    launch_d.kind      = kind_e'(kind_i);
    launch_d.mode      = fit_mode_q;
    launch_d.lim       = lim;
    launch_d.target    = block_index_i;
    launch_d.req       = SIZE_BITS'(size_value_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= '0;
    end else begin
      launch_q <= launch_d;
    end
  end

  // Row of cells
  assign pkt[0] = launch_q;

  for (genvar g = 0; g < BLOCKS; g++) begin : g_cell
    fpba_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .pkt_i      (pkt[g]),
      .wr_i       (wr),
      .pkt_o      (pkt[g+1])
    );
  end

  for (genvar g = 0; g <= BLOCKS; g++) begin : g_live
    assign live[g] = pkt[g].valid;
  end

  // Capture the token leaving the row
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && pkt[BLOCKS].valid) begin
      fin_q <= pkt[BLOCKS];
    end
  end

  // Work out write-back, sums and result from the finished token
  always_comb begin
    wr       = '0;
    int_d    = int_q;
    ext_d    = ext_q;
    status_d = ST_LOADED;
    chosen_d = fin_q.target;
    if (fin_q.kind == KIND_LOAD) begin
      if (fin_q.found) begin
        if (fin_q.pick_used) begin
          int_d = int_q - SUM_W'(fin_q.pick_size);
          ext_d = ext_q + SUM_W'(fin_q.req);
        end else begin
          ext_d = ext_q - SUM_W'(fin_q.pick_size) + SUM_W'(fin_q.req);
        end
        wr.en   = commit;
        wr.idx  = fin_q.target;
        wr.size = fin_q.req;
        wr.used = 1'b0;
      end
    end else if (!fin_q.found) begin
      status_d = ST_NONE;
      chosen_d = '0;
    end else begin
      status_d = ST_ALLOC;
      chosen_d = fin_q.pick;
      if (fin_q.pick_used) begin
        int_d = int_q - SUM_W'(fin_q.req);
      end else begin
        ext_d = ext_q - SUM_W'(fin_q.pick_size);
        int_d = int_q + SUM_W'(fin_q.pick_size) - SUM_W'(fin_q.req);
      end
      wr.en   = commit;
      wr.idx  = fin_q.pick;
      wr.size = fin_q.pick_size - fin_q.req;
      wr.used = 1'b1;
    end
  end

  // Running fragmentation sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q <= '0;
      ext_q <= '0;
    end else if (commit) begin
      int_q <= int_d;
      ext_q <= ext_d;
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q <= status_d;
      chosen_q <= chosen_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign chosen_block_o  = chosen_q;
  assign internal_frag_o = int_q;
  assign external_frag_o = ext_q;

  // Exactly one token lives in the row while scanning, none otherwise
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ($countones(live) == 1))
    else $error("token count wrong while scanning");

  a_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SCAN) |-> (live == '0))
    else $error("stray token outside scan");

  // A result appears only right after a commit
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result without commit");

  // A pending result is never overwritten before transfer
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !commit)
    else $error("result overwritten");

endmodule

`default_nettype wire
